FILE: rtl/tbbp_pkg.sv
// Shared types, constants and the counter update rule for the two-bit
// branch predictor. No dependencies.
package tbbp_pkg;

    localparam int TABLE_BITS  = 12;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    typedef logic [TABLE_BITS-1:0] t_idx;
    typedef logic [1:0]            t_ctr;
    typedef logic [3:0]            t_index_bits;

    localparam t_ctr        CTR_RESET        = 2'd3;
    localparam t_index_bits INDEX_BITS_RESET = 4'd12;

    // Counter table port request, driven by the pipeline
    typedef struct packed {
        logic rd_en;
        t_idx rd_idx;
        logic wr_en;
        t_idx wr_idx;
        t_ctr wr_data;
    } t_tbl_req;

    // Hysteresis update: weak taken falls straight to strong not taken,
    // weak not taken jumps straight to strong taken
    function automatic t_ctr next_ctr(input logic taken, input t_ctr ctr);
        t_ctr res;
        res = ctr;
        case ({taken, ctr})
            3'b000:  res = 2'd0;
            3'b001:  res = 2'd0;
            3'b010:  res = 2'd0;
            3'b011:  res = 2'd2;
            3'b100:  res = 2'd1;
            3'b101:  res = 2'd3;
            3'b110:  res = 2'd3;
            3'b111:  res = 2'd3;
            default: res = ctr;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/tbbp_index.sv
// Index width register and table index generation.
// Depends on tbbp_pkg.
module tbbp_index (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  tbbp_pkg::t_index_bits i_cfg_index_bits,
    input  logic [31:0]          i_branch_address,
    output tbbp_pkg::t_idx       o_idx
);
    import tbbp_pkg::*;

    t_index_bits r_index_bits;
    t_idx        mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= INDEX_BITS_RESET;
        end else if (i_cfg_valid) begin
            r_index_bits <= i_cfg_index_bits;
        end
    end

    // mask is only TABLE_BITS wide, so oversize widths saturate naturally
    always_comb begin
        for (int i = 0; i < TABLE_BITS; i++) begin
            mask[i] = (i < int'(r_index_bits));
        end
    end

    assign o_idx = i_branch_address[TABLE_BITS-1:0] & mask;

endmodule

FILE: rtl/tbbp_table.sv
// Counter table memory with registered read and post-reset clearing pass.
// Depends on tbbp_pkg.
module tbbp_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbbp_pkg::t_tbl_req i_req,
    output tbbp_pkg::t_ctr     o_rd_data,
    output logic               o_busy
);
    import tbbp_pkg::*;

    t_ctr mem [TABLE_DEPTH];
    t_ctr r_rd_data;
    t_idx r_clr_idx;
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + t_idx'(1);
            if (r_clr_idx == t_idx'(TABLE_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_idx] <= CTR_RESET;
        end else if (i_req.wr_en) begin
            mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: rtl/two_bit_branch_predictor.sv
// Top level of the two-bit bimodal branch predictor.
// Depends on tbbp_pkg, tbbp_index and tbbp_table.
//
// Usage
//   Input channel (i_valid/o_ready) carries a branch address and its actual
//   outcome. Output channel (o_valid/i_ready) returns one prediction per
//   input, taken from the counter before it is updated.
//   Config channel (i_cfg_valid/o_cfg_ready) writes index_bits; always ready.
//   Write it only while the predictor is idle.
// Pipeline
//   The table read is registered at the input transfer; the counter update and
//   the output register follow when the read stage may advance.
//   Unless stalled, one item per cycle sustained, set by the single table
//   read-modify-write; a same-index item just behind gets the forwarded counter.
// Reset
//   Synchronous, active low. index_bits returns to 12 and a clearing pass
//   writes every counter to strongly taken, one entry a cycle, with o_ready
//   low throughout. Config writes are accepted during the pass.
// Stall
//   If the receiver holds i_ready low the result waits in the output
//   register; one more item may sit in the read stage, then o_ready drops.
module two_bit_branch_predictor (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  tbbp_pkg::t_index_bits i_cfg_index_bits,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_branch_address,
    input  logic                  i_taken,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_prediction
);
    import tbbp_pkg::*;

    t_idx     idx;
    t_tbl_req req;
    t_ctr     rd_data;
    logic     busy;

    // read stage
    logic r_s1_valid;
    t_idx r_s1_idx;
    logic r_s1_taken;
    logic r_fwd;       // previous item wrote this index in the read cycle
    t_ctr r_fwd_ctr;

    // output register
    logic r_out_valid;
    logic r_out_pred;

    logic accept;
    logic s1_adv;
    logic s1_fire;
    t_ctr ctr;
    t_ctr n_ctr;

    tbbp_index u_index (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index_bits (i_cfg_index_bits),
        .i_branch_address (i_branch_address),
        .o_idx            (idx)
    );

    tbbp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data),
        .o_busy    (busy)
    );

    assign s1_adv  = !r_out_valid || i_ready;
    assign s1_fire = r_s1_valid && s1_adv;
    assign o_ready = !busy && (!r_s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;

    // memory read missed a write landing in the same cycle: use forwarded value
    assign ctr   = r_fwd ? r_fwd_ctr : rd_data;
    assign n_ctr = next_ctr(r_s1_taken, ctr);

    always_comb begin
        req.rd_en   = accept;
        req.rd_idx  = idx;
        req.wr_en   = s1_fire;
        req.wr_idx  = r_s1_idx;
        req.wr_data = n_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx   <= idx;
            r_s1_taken <= i_taken;
            r_fwd      <= s1_fire && (r_s1_idx == idx);
            r_fwd_ctr  <= n_ctr;
        end
        if (s1_fire) begin
            r_out_pred <= ctr[1];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_prediction = r_out_pred;

endmodule

FILE: verif/tb_two_bit_branch_predictor.sv
`timescale 1ns / 100ps
// Self-checking bench for two_bit_branch_predictor: directed and random branch
// streams, checked against a local counter-table predictor.
// Depends on tbbp_pkg and the predictor RTL.
module tb_two_bit_branch_predictor;
    import tbbp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;   // clearing pass plus slowest idling, many times over
    localparam int LONG_STALL   = 300;      // receiver hold-off, far longer than the pipe is deep
    localparam int SETTLE_TICKS = 6;        // settle margin after the pipeline empties

    typedef struct {
        logic [31:0] addr;
        logic        taken;
    } t_branch;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    t_index_bits i_cfg_index_bits = INDEX_BITS_RESET;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [31:0] i_branch_address = '0;
    logic        i_taken          = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic        o_prediction;

    two_bit_branch_predictor uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index_bits (i_cfg_index_bits),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_branch_address (i_branch_address),
        .i_taken          (i_taken),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_prediction     (o_prediction)
    );

    // ------------------------------------------------------------------
    // Local predictor: own copy of the counter table and index width
    // ------------------------------------------------------------------
    t_ctr        counter_model [TABLE_DEPTH];
    t_index_bits model_index_bits;

    t_branch     pending_branches[$];       // filled by the stimulus, drained by the driver
    logic        expected_predictions[$];   // one per accepted branch, oldest first

    int          send_idle_pct = 0;         // chance the sender offers nothing in a cycle
    int          recv_idle_pct = 0;         // chance the receiver stalls in a cycle
    int          stall_requests = 0;        // bumped by the stimulus to ask for a long hold-off
    int          mismatches = 0;

    // Table slot for an address: width saturates at the table size, zero width -> slot 0
    function automatic t_idx table_slot(input logic [31:0] addr);
        int unsigned w;
        logic [31:0] mask;
        w = (model_index_bits > TABLE_BITS) ? TABLE_BITS : model_index_bits;
        if (w == 0)
            return '0;
        mask = (32'd1 << w) - 32'd1;
        return t_idx'(addr & mask);
    endfunction

    // Returns the prediction from the counter as it stands, then trains it
    function automatic logic predict_and_train(input t_branch br);
        t_idx slot;
        t_ctr ctr;
        logic guess;
        slot  = table_slot(br.addr);
        ctr   = counter_model[slot];
        guess = ctr[1];
        if (br.taken)
            counter_model[slot] = (ctr == 2'd0) ? 2'd1 : 2'd3;
        else
            counter_model[slot] = (ctr == 2'd3) ? 2'd2 : 2'd0;
        return guess;
    endfunction

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the head of the pending queue, holds it until transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_branch br;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                // transfer: predict from the model in acceptance order
                br = pending_branches.pop_front();
                expected_predictions.push_back(predict_and_train(br));
            end
            // the payload may change only when nothing is held on the bus
            if (!(i_valid && !o_ready)) begin
                if (pending_branches.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid          <= 1'b1;
                    i_branch_address <= pending_branches[0].addr;
                    i_taken          <= pending_branches[0].taken;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        static int stalls_served = 0;
        static int stall_left    = 0;
        if (stall_requests != stalls_served) begin
            stalls_served = stalls_served + 1;
            stall_left    = LONG_STALL;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result transfer is checked against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_predictions.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected prediction %0b with none outstanding", o_prediction);
            end else begin
                want = expected_predictions.pop_front();
                if (o_prediction !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("prediction mismatch: expected %0b, got %0b",
                                 want, o_prediction);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_branch(input logic [31:0] addr, input logic taken);
        t_branch br;
        br.addr  = addr;
        br.taken = taken;
        pending_branches.push_back(br);
    endtask

    // Wait until everything queued has been sent and every prediction returned
    task automatic drain();
        do @(negedge i_clk);
        while (pending_branches.size() != 0 || i_valid || expected_predictions.size() != 0);
    endtask

    // Register write while idle; the model follows on the transfer
    task automatic write_index_bits(input t_index_bits v);
        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_index_bits <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        model_index_bits = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Half the time a small set of hot slots so counters build history; some full-range
    // addresses, some repeats of the previous one to hit the same-slot bypass
    function automatic logic [31:0] pick_address(input logic [31:0] prev);
        logic [31:0] a;
        a = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: a[11:0] = 12'($urandom_range(0, 15));
            5, 6:          ;
            7, 8:          a = prev;
            default:       a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        static t_index_bits settings [8] =
            '{4'd12, 4'd3, 4'd0, 4'd15, 4'd1, 4'd8, 4'd13, 4'd12};
        logic [31:0] addr;
        int          bias;
        int          mode;

        foreach (counter_model[k])
            counter_model[k] = CTR_RESET;
        model_index_bits = INDEX_BITS_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset width of 12: walk one counter through every
        // transition of the hysteresis rule
        @(negedge i_clk);
        push_branch(32'h0, 1'b0);   // 3 -> 2, predicts taken
        push_branch(32'h0, 1'b0);   // 2 -> 0, weak taken drops straight to strong not taken
        push_branch(32'h0, 1'b0);   // 0 stays 0
        push_branch(32'h0, 1'b1);   // 0 -> 1
        push_branch(32'h0, 1'b0);   // 1 -> 0
        push_branch(32'h0, 1'b1);   // 0 -> 1
        push_branch(32'h0, 1'b1);   // 1 -> 3, weak not taken jumps to strong taken
        push_branch(32'h0, 1'b1);   // 3 stays 3
        push_branch(32'h0, 1'b0);   // 3 -> 2
        push_branch(32'h0, 1'b1);   // 2 -> 3
        // upper bits ignored: the first two alias slot 0 above, the next two share slot 0xFFF
        push_branch(32'hFFFF_F000, 1'b0);
        push_branch(32'h0000_1000, 1'b0);
        push_branch(32'hFFFF_FFFF, 1'b0);
        push_branch(32'h0000_0FFF, 1'b1);
        push_branch(32'hAAAA_AAAA, 1'b0);
        push_branch(32'h5555_5555, 1'b1);

        // No index bits: every address lands on slot 0, table kept across the write
        write_index_bits(4'd0);
        @(negedge i_clk);
        push_branch(32'hFFFF_FFFF, 1'b1);
        push_branch(32'h1234_5678, 1'b0);
        push_branch(32'h0000_0001, 1'b0);
        push_branch(32'h8000_0000, 1'b0);

        // Width beyond the table saturates to the full table
        write_index_bits(4'd15);
        @(negedge i_clk);
        push_branch(32'hFFFF_FFFF, 1'b0);
        push_branch(32'h0000_1FFF, 1'b0);
        push_branch(32'h0000_0FFF, 1'b1);
        push_branch(32'h0000_5000, 1'b1);

        // Random phases across several widths; idling moves through three regimes
        addr = '0;
        foreach (settings[p]) begin
            write_index_bits(settings[p]);
            @(negedge i_clk);
            mode = p * 3 / 8;
            send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 85 : 0;
            recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 26 : 0;
            bias = 20 + 30 * $urandom_range(0, 2);

            // first phase: long receiver hold-off with the sender still busy,
            // so the pipe fills and input ready drops
            if (p == 0)
                stall_requests = stall_requests + 1;

            for (int n = 0; n < 125; n++) begin
                addr = pick_address(addr);
                push_branch(addr, $urandom_range(0, 99) < bias);
                // second phase: sender pauses mid-way until all results are back
                if (p == 1 && n == 60)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
